[hdl/hd2d_pkg.sv]
// Package for the 2D heat diffusion step: sizes, field widths, sample type
// and configuration register indexes.
// No dependencies; imported by heat_diffusion_2d_step.
package hd2d_pkg;

  // Grid limits and the counter widths that follow from them.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Field and register widths.
  localparam int SAMPLE_W     = 24;
  localparam int COEFF_W      = 16;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;

  // Stream data widths, padded to whole bytes.
  localparam int S_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = SAMPLE_W + ROW_W + COL_W;
  localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

  // Arithmetic widths: the Laplacian of four neighbours minus four times
  // the centre, its product with the coefficient, and the fraction bits.
  localparam int LAP_W     = SAMPLE_W + 3;
  localparam int PROD_W    = LAP_W + COEFF_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int DELTA_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W     = DELTA_W + 1;

  // Saturation limits of a sample.
  localparam logic signed [SUM_W-1:0] SAMPLE_MAX = SUM_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -SUM_W'(2 ** (SAMPLE_W - 1));

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEFF  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

endpackage

[hdl/heat_diffusion_2d_step.sv]
// One explicit time step of the 2D heat equation over a raster-ordered grid.
// Two line stores, a four-stage pipeline and a two-phase output register.
// Depends on hd2d_pkg.
//
// Each result passes the stage 1, 2, 3 and output registers once the sample
// that completes it is taken; results run one grid row behind the input
// stream. Throughput: one item per cycle while the output port accepts; a
// last-row item yields two results, so there the output port sets the pace.
// Reset clears the pipeline, the counters and the registers (coefficient 0,
// width 3, height 3); the line stores are not cleared and need no pass.
module heat_diffusion_2d_step
  import hd2d_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_DATA_W-1:0]   s_axis_tdata,   // [23:0] temperature_in
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_DATA_W-1:0]   m_axis_tdata,   // [23:0] temperature_out,
                                                // [35:24] row_index,
                                                // [45:36] column_index, rest zero
  output logic                  m_axis_tlast,   // last_of_frame
  output logic                  m_axis_tuser    // last_of_run
);

  // Per-item control and payload carried down the pipeline.
  typedef struct packed {
    sample_t          x;
    sample_t          center;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             pass;
    logic             has_first;
    logic             has_second;
    logic             last_col;
  } item_t;

  // ---------------------------------------------------------------------
  // Configuration registers, held as clamped last-index values.
  logic [COEFF_W-1:0] coeff_q;
  logic [COL_W-1:0]   wm1_q;
  logic [ROW_W-1:0]   hm1_q;
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;

  assign cfg_w = cfg_data_i[WIDTH_REG_W-1:0];
  assign cfg_h = cfg_data_i[HEIGHT_REG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
      wm1_q   <= COL_W'(2);
      hm1_q   <= ROW_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COEFF: begin
          coeff_q <= cfg_data_i[COEFF_W-1:0];
        end
        CFG_WIDTH: begin
          if (cfg_w < WIDTH_REG_W'(3)) begin
            wm1_q <= COL_W'(2);
          end else if (cfg_w > WIDTH_REG_W'(MAX_WIDTH)) begin
            wm1_q <= COL_W'(MAX_WIDTH - 1);
          end else begin
            wm1_q <= COL_W'(cfg_w - WIDTH_REG_W'(1));
          end
        end
        CFG_HEIGHT: begin
          if (cfg_h < HEIGHT_REG_W'(3)) begin
            hm1_q <= ROW_W'(2);
          end else if (cfg_h > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            hm1_q <= ROW_W'(MAX_HEIGHT - 1);
          end else begin
            hm1_q <= ROW_W'(cfg_h - HEIGHT_REG_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake chain: each stage moves on when the next one is empty or
  // moving, so bubbles never hold up the input.
  logic s1_v_q, s2_v_q, s3_v_q, o_v_q, o_sel_q;
  item_t s1_q, s2_q, s3_q, o_q;
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic in_acc, out_hs;

  assign out_rdy = !o_v_q || (m_axis_tready && (o_sel_q || !o_q.has_second));
  assign s3_rdy  = !s3_v_q || out_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;

  assign s_axis_tready = s1_rdy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_hs        = m_axis_tvalid && m_axis_tready;

  // ---------------------------------------------------------------------
  // Raster position of the incoming item.
  logic [COL_W-1:0] col_q, col_nx;
  logic [ROW_W-1:0] row_q;
  logic             last_col, last_row;
  sample_t          x_in;

  assign x_in     = s_axis_tdata[SAMPLE_W-1:0];
  assign col_nx   = col_q + COL_W'(1);
  assign last_col = col_q >= wm1_q;
  assign last_row = row_q >= hm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_nx;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: store A holds even rows, store B odd rows. Each is read
  // at the current and the next column; the store of the current row is
  // written with the new sample after its old value has been read.
  sample_t mem_a [MAX_WIDTH];
  sample_t mem_b [MAX_WIDTH];
  sample_t a_rd0_q, a_rd1_q, b_rd0_q, b_rd1_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!row_q[0]) begin
        mem_a[col_q] <= x_in;
      end
      a_rd0_q <= mem_a[col_q];
      a_rd1_q <= mem_a[col_nx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (row_q[0]) begin
        mem_b[col_q] <= x_in;
      end
      b_rd0_q <= mem_b[col_q];
      b_rd1_q <= mem_b[col_nx];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 item: position, flags and the new sample (the lower neighbour).
  item_t s1_d;

  always_comb begin
    s1_d            = '0;
    s1_d.x          = x_in;
    s1_d.row        = row_q;
    s1_d.col        = col_q;
    s1_d.pass       = (row_q == ROW_W'(1)) || (col_q == '0) || last_col;
    s1_d.has_first  = row_q != '0;
    s1_d.has_second = last_row;
    s1_d.last_col   = last_col;
  end

  // Neighbours of the point one row up; the left one is the previous centre.
  sample_t up, center, right, left_q;
  logic signed [LAP_W-1:0] lap_d, lap_q;
  item_t s2_d;

  assign up     = s1_q.row[0] ? b_rd0_q : a_rd0_q;
  assign center = s1_q.row[0] ? a_rd0_q : b_rd0_q;
  assign right  = s1_q.row[0] ? a_rd1_q : b_rd1_q;
  assign lap_d  = LAP_W'(up) + LAP_W'(s1_q.x) + LAP_W'(left_q) + LAP_W'(right)
                - (LAP_W'(center) <<< 2);

  // Stage 2 item: the stage 1 item with the centre sample filled in.
  always_comb begin
    s2_d        = s1_q;
    s2_d.center = center;
  end

  // Stage 3 arithmetic: scale by the coefficient.
  logic signed [COEFF_W:0]  coeff_s;
  logic signed [PROD_W-1:0] prod_d, prod_q;

  assign coeff_s = $signed({1'b0, coeff_q});
  assign prod_d  = PROD_W'(coeff_s) * PROD_W'(lap_q);

  // Output stage arithmetic: round half up, add, saturate; border points pass unchanged.
  logic signed [PROD_W-1:0]  rnd;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W-1:0]   sum;
  sample_t                   y_d, y_q;

  assign rnd   = prod_q + PROD_W'(2 ** (FRAC_BITS - 1));
  assign delta = rnd[PROD_W-1:FRAC_BITS];
  assign sum   = SUM_W'(s3_q.center) + SUM_W'(delta);

  always_comb begin
    if (s3_q.pass) begin
      y_d = s3_q.center;
    end else if (sum > SAMPLE_MAX) begin
      y_d = sample_t'(SAMPLE_MAX);
    end else if (sum < SAMPLE_MIN) begin
      y_d = sample_t'(SAMPLE_MIN);
    end else begin
      y_d = sum[SAMPLE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline valid bits and output phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      o_v_q   <= 1'b0;
      o_sel_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= in_acc && (s1_d.has_first || s1_d.has_second);
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
      if (out_rdy) begin
        o_v_q   <= s3_v_q;
        o_sel_q <= !s3_q.has_first;
      end else if (out_hs && !o_sel_q) begin
        o_sel_q <= 1'b1;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_v_q && s2_rdy) begin
      s2_q   <= s2_d;
      lap_q  <= lap_d;
      left_q <= center;
    end
    if (s2_v_q && s3_rdy) begin
      s3_q   <= s2_q;
      prod_q <= prod_d;
    end
    if (s3_v_q && out_rdy) begin
      o_q <= s3_q;
      y_q <= y_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output: the update of the row above first, then on the last row the
  // sample itself.
  sample_t          temp_out;
  logic [ROW_W-1:0] row_out;

  assign temp_out = o_sel_q ? o_q.x : y_q;
  assign row_out  = o_sel_q ? o_q.row : o_q.row - ROW_W'(1);

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {(M_DATA_W - M_FIELDS_W)'(0), o_q.col, row_out, temp_out};
  assign m_axis_tuser  = o_sel_q || !o_q.has_second;
  assign m_axis_tlast  = o_sel_q && o_q.last_col;

  // ---------------------------------------------------------------------
  // Checks.
  a_frame_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("frame end without run end");

  a_second_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q && o_sel_q |-> o_q.has_second)
    else $error("second result shown for an item without one");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && !o_sel_q && o_q.has_second |=> o_v_q && o_sel_q)
    else $error("second result of a pair lost");

  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_v_q && s2_v_q && s3_v_q && o_v_q)
    else $error("input stalled while the pipeline has room");

endmodule

[tb/tb_heat_diffusion_2d_step.sv]
// Self-checking testbench for heat_diffusion_2d_step: drives whole grids through
// the input stream and checks every updated sample against a local predictor.
// Depends on hd2d_pkg and the RTL of heat_diffusion_2d_step only.
module tb_heat_diffusion_2d_step
  import hd2d_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam sample_t HOT  = 24'sh7FFFFF;
  localparam sample_t COLD = 24'sh800000;

  // Idling schemes applied to the two stream sides.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_e;

  // Kinds of grid content.
  typedef enum int {
    FILL_NOISE,
    FILL_SMOOTH,
    FILL_EXTREME
  } fill_e;

  // One updated sample as the block should emit it.
  typedef struct {
    sample_t           temp;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              run_end;
    logic              frame_end;
  } result_t;

  // Predicts the next time step from the accepted items and checks the results.
  class diffusion_scoreboard;
    logic [COEFF_W-1:0]      coeff;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    sample_t                 row_store[2][MAX_WIDTH];
    int unsigned             row_count;
    int unsigned             col_count;
    result_t                 expected_q[$];
    int unsigned             mismatches;

    function new();
      coeff      = '0;
      width_reg  = WIDTH_REG_W'(3);
      height_reg = HEIGHT_REG_W'(3);
      row_count  = 0;
      col_count  = 0;
      mismatches = 0;
      foreach (row_store[p, i]) row_store[p][i] = '0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_COEFF:  coeff = value[COEFF_W-1:0];
        CFG_WIDTH:  width_reg = value[WIDTH_REG_W-1:0];
        CFG_HEIGHT: height_reg = value[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    endfunction

    // Sizes in use: the registers clamped to the legal range.
    function int unsigned grid_columns();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned grid_rows();
      if (height_reg < 3) return 3;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Five-point update with rounding half up and saturation.
    function sample_t diffuse(sample_t centre, sample_t up, sample_t down,
                              sample_t left, sample_t right);
      logic signed [LAP_W-1:0]   lap;
      logic signed [PROD_W-1:0]  prod;
      logic signed [DELTA_W-1:0] delta;
      logic signed [SUM_W-1:0]   sum;
      lap   = LAP_W'(up) + LAP_W'(down) + LAP_W'(left) + LAP_W'(right)
            - (LAP_W'(centre) <<< 2);
      prod  = PROD_W'($signed({1'b0, coeff})) * PROD_W'(lap);
      delta = DELTA_W'((prod + PROD_W'(32768)) >>> FRAC_BITS);
      sum   = SUM_W'(centre) + SUM_W'(delta);
      if (sum > SAMPLE_MAX) sum = SAMPLE_MAX;
      if (sum < SAMPLE_MIN) sum = SAMPLE_MIN;
      return sample_t'(sum);
    endfunction

    // An accepted item completes the sample one row above it, and on the
    // last row it also stands for itself.
    function void note_sample(sample_t x);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned p;
      bit          last_col;
      bit          last_row;
      sample_t     centre;
      result_t     res;
      w = grid_columns();
      h = grid_rows();
      r = row_count;
      c = col_count;
      p = (r + 1) % 2;
      last_col = c >= w - 1;
      last_row = r >= h - 1;
      if (r >= 1) begin
        centre = row_store[p][c];
        if (r == 1 || c == 0 || last_col) begin
          res.temp = centre;
        end else begin
          res.temp = diffuse(centre, row_store[r % 2][c], x,
                             row_store[p][c - 1], row_store[p][c + 1]);
        end
        res.row       = ROW_W'(r - 1);
        res.col       = COL_W'(c);
        res.run_end   = !last_row;
        res.frame_end = 1'b0;
        expected_q.insert(expected_q.size(), res);
      end
      row_store[r % 2][c] = x;
      if (last_row) begin
        res.temp      = x;
        res.row       = ROW_W'(r);
        res.col       = COL_W'(c);
        res.run_end   = 1'b1;
        res.frame_end = last_col;
        expected_q.insert(expected_q.size(), res);
      end
      if (last_col) begin
        col_count = 0;
        row_count = last_row ? 0 : r + 1;
      end else begin
        col_count = c + 1;
      end
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data, logic frame_end, logic run_end);
      result_t want;
      sample_t got_temp;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual tdata %h",
                 $time, data);
        return;
      end
      want     = expected_q.pop_front();
      got_temp = data[SAMPLE_W-1:0];
      compare_field("temperature_out", want.temp, got_temp);
      compare_field("row_index", want.row, data[SAMPLE_W +: ROW_W]);
      compare_field("column_index", want.col, data[SAMPLE_W + ROW_W +: COL_W]);
      compare_field("last_of_run", want.run_end, run_end);
      compare_field("last_of_frame", want.frame_end, frame_end);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;   // [23:0] temperature_in
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;   // [23:0] temperature_out, [35:24] row_index,
                                         // [45:36] column_index
  logic                  m_axis_tlast;   // last_of_frame
  logic                  m_axis_tuser;   // last_of_run

  diffusion_scoreboard sb = new();
  idle_e               idle_mode = IDLE_NONE;
  int unsigned         cycle_count = 0;

  heat_diffusion_2d_step u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned sender_idle_pct();
    case (idle_mode)
      IDLE_SENDER: return 77;
      IDLE_BOTH:   return 10;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 77;
      IDLE_BOTH:     return 10;
      default:       return 0;
    endcase
  endfunction

  // Receiver side: ready changes at the falling edge only.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // Every accepted result goes straight to the checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_register(idx, value);
  endtask

  task automatic program_grid(input logic [CFG_DATA_W-1:0] coeff,
                              input logic [CFG_DATA_W-1:0] width,
                              input logic [CFG_DATA_W-1:0] height);
    write_register(CFG_COEFF, coeff);
    write_register(CFG_WIDTH, width);
    write_register(CFG_HEIGHT, height);
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // Offer one item, with random idle cycles first, and hold it until taken.
  task automatic push_sample(input sample_t value);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(value);
  endtask

  // Stop sending, then wait for every expected result and the pipeline tail.
  task automatic drain();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A 3x3 grid with its own value at the centre and at the top middle.
  task automatic send_probe(input sample_t border, input sample_t top, input sample_t centre);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r == 1 && c == 1) push_sample(centre);
        else if (r == 0 && c == 1) push_sample(top);
        else push_sample(border);
      end
    end
  endtask

  // One whole grid at the programmed size.
  task automatic send_grid(input fill_e fill);
    sample_t     base;
    sample_t     value;
    int unsigned total;
    total = sb.grid_columns() * sb.grid_rows();
    base  = sample_t'($urandom());
    for (int unsigned i = 0; i < total; i++) begin
      case (fill)
        FILL_SMOOTH: value = sample_t'(int'(base) + int'($urandom_range(8191)) - 4096);
        FILL_EXTREME: begin
          case ($urandom_range(3))
            0:       value = HOT;
            1:       value = COLD;
            2:       value = '0;
            default: value = '1;
          endcase
        end
        default: value = sample_t'($urandom());
      endcase
      push_sample(value);
    end
  endtask

  // Stimulus.
  initial begin
    int unsigned           random_items;
    int unsigned           phase;
    logic [CFG_DATA_W-1:0] coeff;
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] height;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_COEFF;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    random_items  = 0;
    phase         = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: saturation both ways at the largest coefficient and the
    // smallest grid (size registers below range), then a negative half step.
    program_grid(16'hFFFF, 16'd0, 16'd0);
    send_probe(HOT, HOT, COLD);
    send_probe(COLD, COLD, HOT);
    drain();
    program_grid(16'h8000, 16'd3, 16'd3);
    send_probe('0, '1, '0);
    drain();

    // Random small grids, cycling through the idling schemes.
    while (random_items < RANDOM_ITEMS) begin
      idle_mode = idle_e'(phase % 4);
      case ($urandom_range(5))
        0:       coeff = '0;
        1:       coeff = 16'hFFFF;
        2:       coeff = CFG_DATA_W'($urandom());
        default: coeff = CFG_DATA_W'($urandom_range(16384));
      endcase
      width  = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2))
                                        : CFG_DATA_W'($urandom_range(3, 12));
      height = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2))
                                        : CFG_DATA_W'($urandom_range(3, 8));
      program_grid(coeff, width, height);
      repeat ($urandom_range(1, 3)) begin
        send_grid(fill_e'($urandom_range(2)));
        random_items += sb.grid_columns() * sb.grid_rows();
      end
      drain();
      phase++;
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
